[rtl/core/sip_hl_pkg.sv]
// Shared types and constants of the SIP header locator.
// Used by the scanner, the result queue and the top level; depends on nothing.
`default_nettype none

package sip_hl_pkg;

    // Width of the reported offset and length fields.
    localparam int FIELD_W = 16;

    // Default width of the internal offset counter.
    localparam int DEFAULT_OFFSET_BITS = 16;

    // Result queue depth; the input stalls while fewer than two entries are free.
    localparam int FIFO_DEPTH = 4;

    // Header kinds.
    localparam logic [1:0] KIND_FROM = 2'd0;
    localparam logic [1:0] KIND_TO   = 2'd1;
    localparam logic [1:0] KIND_CSEQ = 2'd2;

    // Status codes.
    localparam logic [1:0] STAT_MORE    = 2'd0;
    localparam logic [1:0] STAT_DONE    = 2'd1;
    localparam logic [1:0] STAT_MISSING = 2'd2;

    typedef struct packed {
        logic [1:0]         kind;
        logic [FIELD_W-1:0] start;
        logic [FIELD_W-1:0] len;
        logic [1:0]         status;
        logic               last;
    } result_t;

    // Up to two results caused by one byte; res1 is used only with res0.
    typedef struct packed {
        logic    valid0;
        logic    valid1;
        result_t res0;
        result_t res1;
    } result_push_t;

endpackage

`default_nettype wire

[rtl/core/sip_hl_scanner.sv]
// Byte scanner of the SIP header locator: state registers and next-state logic.
// Depends on sip_hl_pkg for the result types and codes.
`default_nettype none

module sip_hl_scanner
    import sip_hl_pkg::*;
#(
    parameter int OFFSET_BITS = DEFAULT_OFFSET_BITS
) (
    input  wire logic         clk,
    input  wire logic         rst_n,
    input  wire logic         accept,
    input  wire logic [7:0]   data_byte,
    input  wire logic         first,
    input  wire logic         final_req,
    input  wire logic [2:0]   want_mask,
    output result_push_t      push
);

    localparam logic [OFFSET_BITS-1:0] OFF_MAX = {OFFSET_BITS{1'b1}};
    localparam int WIDE_W = (OFFSET_BITS > FIELD_W) ? OFFSET_BITS : FIELD_W;

    localparam logic [7:0] CASE_BIT  = 8'h20;
    localparam logic [7:0] CHR_LF    = 8'h0A;
    localparam logic [7:0] CHR_CR    = 8'h0D;
    localparam logic [7:0] CHR_TAB   = 8'h09;
    localparam logic [7:0] CHR_SP    = 8'h20;
    localparam logic [7:0] CHR_COLON = 8'h3A;
    localparam logic [7:0] LC_F      = 8'h66;
    localparam logic [7:0] LC_T      = 8'h74;
    localparam logic [7:0] LC_C      = 8'h63;
    localparam logic [7:0] LC_R      = 8'h72;
    localparam logic [7:0] LC_O      = 8'h6F;
    localparam logic [7:0] LC_M      = 8'h6D;
    localparam logic [7:0] LC_S      = 8'h73;
    localparam logic [7:0] LC_E      = 8'h65;
    localparam logic [7:0] LC_Q      = 8'h71;

    localparam logic [2:0] WANT_FROM = 3'b001;
    localparam logic [2:0] WANT_TO   = 3'b010;
    localparam logic [2:0] WANT_CSEQ = 3'b100;

    typedef enum logic [13:0] {
        ST_MID   = 14'h0001,
        ST_BOL   = 14'h0002,
        ST_NAME  = 14'h0004,
        ST_VAL   = 14'h0008,
        ST_EOL   = 14'h0010,
        ST_F1    = 14'h0020,
        ST_F2    = 14'h0040,
        ST_F3    = 14'h0080,
        ST_T1    = 14'h0100,
        ST_C1    = 14'h0200,
        ST_C2    = 14'h0400,
        ST_C3    = 14'h0800,
        ST_CSWS  = 14'h1000,
        ST_CSDIG = 14'h2000
    } scan_state_t;

    typedef struct packed {
        scan_state_t state;
        logic        rep;
        logic        load;
        logic [1:0]  kind;
    } basic_out_t;

    function automatic logic is_space(input logic [7:0] c);
        return (c == CHR_SP) || (c inside {[CHR_TAB:CHR_CR]});
    endfunction

    function automatic logic is_digit(input logic [7:0] c);
        return c inside {[8'h30:8'h39]};
    endfunction

    // Handles one byte in a line-level state. On a report the state given is the
    // one taken when other headers are still pending.
    function automatic basic_out_t basic_step(
        input scan_state_t s_in,
        input logic [7:0]  c,
        input logic [2:0]  wl,
        input logic [1:0]  ch
    );
        basic_out_t  r;
        scan_state_t s;
        logic [7:0]  lc;
        lc     = c | CASE_BIT;
        r.rep  = 1'b0;
        r.load = 1'b0;
        r.kind = ch;
        s      = (s_in inside {ST_MID, ST_BOL, ST_NAME, ST_VAL, ST_EOL}) ? s_in : ST_MID;
        if (c == CHR_LF || c == CHR_CR) begin
            if (s == ST_NAME)
                s = ST_VAL;
            else if (s == ST_VAL || s == ST_EOL)
                s = ST_EOL;
            else
                s = ST_BOL;
        end else if (c == CHR_SP || c == CHR_TAB) begin
            if (s == ST_NAME || s == ST_EOL)
                s = ST_VAL;
            else if (s == ST_BOL)
                s = ST_MID;
        end else if (c == CHR_COLON) begin
            if (s == ST_NAME || s == ST_VAL) begin
                s = (ch == KIND_CSEQ) ? ST_CSWS : ST_VAL;
            end else if (s == ST_EOL) begin
                r.rep = 1'b1;
                s     = ST_MID;
            end else if (s == ST_BOL) begin
                s = ST_MID;
            end
        end else if (lc == LC_F || lc == LC_T || lc == LC_C) begin
            if (s != ST_VAL) begin
                if (s == ST_EOL) begin
                    r.rep = 1'b1;
                    s     = ST_BOL;
                end
                if (s != ST_BOL) begin
                    s = ST_MID;
                end else if (lc == LC_F) begin
                    if ((wl & WANT_FROM) != 3'b000) begin
                        s      = ST_F1;
                        r.load = 1'b1;
                        r.kind = KIND_FROM;
                    end
                end else if (lc == LC_T) begin
                    if ((wl & WANT_TO) != 3'b000) begin
                        s      = ST_T1;
                        r.load = 1'b1;
                        r.kind = KIND_TO;
                    end
                end else begin
                    if ((wl & WANT_CSEQ) != 3'b000) begin
                        s      = ST_C1;
                        r.load = 1'b1;
                        r.kind = KIND_CSEQ;
                    end
                end
            end
        end else begin
            if (s == ST_BOL || s == ST_NAME) begin
                s = ST_MID;
            end else if (s == ST_EOL) begin
                r.rep = 1'b1;
                s     = ST_MID;
            end
        end
        r.state = s;
        return r;
    endfunction

    scan_state_t            state_reg, state_next;
    logic [OFFSET_BITS-1:0] offset_reg, offset_next;
    logic [OFFSET_BITS-1:0] hstart_reg, hstart_next;
    logic [2:0]             pending_reg, pending_next;
    logic [1:0]             cur_hdr_reg, cur_hdr_next;
    logic                   active_reg, active_next;
    logic [2:0]             want_reg, want_next;

    scan_state_t            s0, nxt, back;
    logic [OFFSET_BITS-1:0] off0, hs0, off_inc, rep_end, len;
    logic [2:0]             pm0, pm1, wl0, hdr_bit;
    logic [1:0]             ch0, kind_new;
    logic                   act0, act1, act2;
    logic                   use_basic, rep_p, rep_f, rep, done, missing, load;
    logic [7:0]             lc;
    basic_out_t             bo;
    logic [WIDE_W-1:0]      start_wide, len_wide;
    result_t                rep_res, miss_res;

    always_comb
    begin
        s0   = state_reg;
        off0 = offset_reg;
        hs0  = hstart_reg;
        pm0  = pending_reg;
        ch0  = cur_hdr_reg;
        act0 = active_reg;
        wl0  = want_reg;
        if (first)
        begin
            s0   = ST_MID;
            off0 = '0;
            hs0  = '0;
            ch0  = KIND_FROM;
            wl0  = want_mask;
            pm0  = want_mask;
            act0 = 1'b1;
        end

        // A failed partial name falls back to an earlier state and the byte is
        // seen again from there, as though the skipped letters were replayed.
        lc        = data_byte | CASE_BIT;
        use_basic = 1'b0;
        back      = s0;
        nxt       = s0;
        rep_p     = 1'b0;
        load      = 1'b0;
        kind_new  = ch0;
        case (s0)
            ST_F1:
                if (lc == LC_R) nxt = ST_F2;
                else begin use_basic = 1'b1; back = ST_NAME; end
            ST_F2:
                if (lc == LC_O) nxt = ST_F3;
                else begin use_basic = 1'b1; back = ST_MID; end
            ST_F3:
                if (lc == LC_M) nxt = ST_NAME;
                else begin use_basic = 1'b1; back = ST_MID; end
            ST_T1:
                if (lc == LC_O) nxt = ST_NAME;
                else begin use_basic = 1'b1; back = ST_NAME; end
            ST_C1:
                if (lc == LC_S) nxt = ST_C2;
                else begin use_basic = 1'b1; back = ST_BOL; end
            ST_C2:
                if (lc == LC_E) nxt = ST_C3;
                else begin use_basic = 1'b1; back = ST_MID; end
            ST_C3:
                if (lc == LC_Q) nxt = ST_NAME;
                else begin use_basic = 1'b1; back = ST_MID; end
            ST_CSWS, ST_CSDIG:
                if (s0 == ST_CSWS && is_space(data_byte))
                    nxt = s0;
                else if (is_digit(data_byte))
                    nxt = ST_CSDIG;
                else
                begin
                    rep_p = 1'b1;
                    nxt   = ST_MID;
                end
            default:
                use_basic = 1'b1;
        endcase
        bo = basic_step(back, data_byte, wl0, ch0);
        if (use_basic)
        begin
            nxt      = bo.state;
            rep_p    = bo.rep;
            load     = bo.load;
            kind_new = bo.kind;
        end

        // A buffer that ends inside the CSeq number closes the span at its last byte.
        rep_f   = final_req && !rep_p && (nxt == ST_CSWS || nxt == ST_CSDIG);
        rep     = act0 && (rep_p || rep_f);
        off_inc = (off0 == OFF_MAX) ? OFF_MAX : off0 + OFFSET_BITS'(1);
        rep_end = rep_p ? off0 : off_inc;
        len     = (rep_end >= hs0) ? rep_end - hs0 : '0;
        hdr_bit = 3'b001 << ch0;
        pm1     = rep ? (pm0 & ~hdr_bit) : pm0;
        done    = rep && (pm1 == 3'b000);
        act1    = act0 && !done;
        missing = final_req && act1;
        act2    = act1 && !final_req;

        state_next   = act0 ? nxt : s0;
        hstart_next  = (act0 && load) ? off0 : hs0;
        cur_hdr_next = (act0 && load) ? kind_new : ch0;
        want_next    = wl0;
        pending_next = pm1;
        active_next  = act2;
        offset_next  = (act2 && off0 != OFF_MAX) ? off0 + OFFSET_BITS'(1) : off0;

        start_wide     = WIDE_W'(hs0);
        len_wide       = WIDE_W'(len);
        rep_res.kind   = ch0;
        rep_res.start  = start_wide[FIELD_W-1:0];
        rep_res.len    = len_wide[FIELD_W-1:0];
        rep_res.status = done ? STAT_DONE : STAT_MORE;
        rep_res.last   = !missing;

        miss_res.kind   = KIND_FROM;
        miss_res.start  = '0;
        miss_res.len    = '0;
        miss_res.status = STAT_MISSING;
        miss_res.last   = 1'b1;

        push.valid0 = accept && (rep || missing);
        push.valid1 = accept && rep && missing;
        push.res0   = rep ? rep_res : miss_res;
        push.res1   = miss_res;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= ST_MID;
            offset_reg  <= '0;
            hstart_reg  <= '0;
            pending_reg <= '0;
            cur_hdr_reg <= KIND_FROM;
            active_reg  <= 1'b0;
            want_reg    <= '0;
        end
        else if (accept)
        begin
            state_reg   <= state_next;
            offset_reg  <= offset_next;
            hstart_reg  <= hstart_next;
            pending_reg <= pending_next;
            cur_hdr_reg <= cur_hdr_next;
            active_reg  <= active_next;
            want_reg    <= want_next;
        end
    end

endmodule

`default_nettype wire

[rtl/core/sip_hl_result_fifo.sv]
// Result queue of the SIP header locator: takes up to two results a cycle,
// hands out one per transfer. Depends on sip_hl_pkg.
`default_nettype none

module sip_hl_result_fifo
    import sip_hl_pkg::*;
(
    input  wire logic                           clk,
    input  wire logic                           rst_n,
    input  wire result_push_t                   push,
    output logic                                out_valid,
    input  wire logic                           out_stall,
    output result_t                             head,
    output logic [$clog2(FIFO_DEPTH+1)-1:0]     level
);

    localparam int PTR_W   = $clog2(FIFO_DEPTH);
    localparam int LEVEL_W = $clog2(FIFO_DEPTH+1);

    result_t            mem_reg [FIFO_DEPTH];
    logic [PTR_W-1:0]   wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0]   rd_ptr_reg, rd_ptr_next;
    logic [LEVEL_W-1:0] level_reg, level_next;
    logic [1:0]         push_n;
    logic               pop;

    always_comb
    begin
        push_n      = {1'b0, push.valid0} + {1'b0, push.valid1};
        pop         = out_valid && !out_stall;
        wr_ptr_next = wr_ptr_reg + PTR_W'(push_n);
        rd_ptr_next = rd_ptr_reg + PTR_W'(pop);
        level_next  = level_reg + LEVEL_W'(push_n) - LEVEL_W'(pop);
    end

    assign out_valid = (level_reg != '0);
    assign head      = mem_reg[rd_ptr_reg];
    assign level     = level_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            level_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            level_reg  <= level_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push.valid0)
            mem_reg[wr_ptr_reg] <= push.res0;
        if (push.valid1)
            mem_reg[wr_ptr_reg + PTR_W'(1)] <= push.res1;
    end

endmodule

`default_nettype wire

[rtl/core/sip_header_locator_core.sv]
// SIP header locator, top level: scanner plus result queue.
// Depends on sip_hl_pkg, sip_hl_scanner and sip_hl_result_fifo.
//
// The block takes one byte of a SIP request per clock and reports where the
// From, To and CSeq headers begin (compact forms and any letter case
// accepted) and how long each is. A byte with first set restarts the scan at
// offset zero and samples want_mask. The byte's state update is done in the
// cycle of its transfer, so a byte can be taken every clock; each byte causes
// zero, one or two results, which pass through a four-entry queue, and the
// input stalls only while fewer than two queue entries are free. The first
// result of a byte can be taken on the clock after its transfer. A scan that
// ends without all requested headers gives a missing status at its last
// byte, after any result that the last byte closes.
`default_nettype none

module sip_header_locator_core
    import sip_hl_pkg::*;
#(
    parameter int OFFSET_BITS = DEFAULT_OFFSET_BITS
) (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               in_valid,
    output logic                    in_stall,
    input  wire logic [7:0]         data_byte,
    input  wire logic               first,
    input  wire logic               final_req,
    input  wire logic [2:0]         want_mask,
    output logic                    out_valid,
    input  wire logic               out_stall,
    output logic [1:0]              header_kind,
    output logic [FIELD_W-1:0]      start_offset,
    output logic [FIELD_W-1:0]      span_length,
    output logic [1:0]              status,
    output logic                    last_of_run
);

    localparam int LEVEL_W = $clog2(FIFO_DEPTH+1);

    result_push_t       push;
    result_t            head;
    logic [LEVEL_W-1:0] level;
    logic               accept;

    // Room for two results must be there before a byte is taken.
    assign in_stall = (level > LEVEL_W'(FIFO_DEPTH - 2));
    assign accept   = in_valid && !in_stall;

    sip_hl_scanner #(
        .OFFSET_BITS (OFFSET_BITS)
    ) u_scanner (
        .clk       (clk),
        .rst_n     (rst_n),
        .accept    (accept),
        .data_byte (data_byte),
        .first     (first),
        .final_req (final_req),
        .want_mask (want_mask),
        .push      (push)
    );

    sip_hl_result_fifo u_fifo (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .head      (head),
        .level     (level)
    );

    assign header_kind  = head.kind;
    assign start_offset = head.start;
    assign span_length  = head.len;
    assign status       = head.status;
    assign last_of_run  = head.last;

    a_level_bound: assert property (@(posedge clk) disable iff (!rst_n)
        level <= LEVEL_W'(FIFO_DEPTH))
        else $error("result queue overfilled");

    a_pair_marks: assert property (@(posedge clk) disable iff (!rst_n)
        push.valid1 |-> push.valid0 && push.res1.last && !push.res0.last)
        else $error("second result of a byte without proper last marks");

    a_single_last: assert property (@(posedge clk) disable iff (!rst_n)
        (push.valid0 && !push.valid1) |-> push.res0.last)
        else $error("single result of a byte not marked last");

    a_push_needs_transfer: assert property (@(posedge clk) disable iff (!rst_n)
        !accept |-> !push.valid0 && !push.valid1)
        else $error("result produced without an input transfer");

endmodule

`default_nettype wire

[tb/tb.sv]
// Testbench for sip_header_locator_core: a byte-serial SIP request scanner.
// Depends on sip_hl_pkg and the core; it checks every result against its own
// span predictor and drives random idle and stall patterns on both channels.

module tb;
    import sip_hl_pkg::*;

    localparam int unsigned OFF_MAX = (1 << DEFAULT_OFFSET_BITS) - 1;
    localparam logic [7:0] CASE_BIT = 8'h20;
    localparam logic [7:0] CH_TAB = 8'h09;
    localparam logic [7:0] CH_LF = 8'h0A;
    localparam logic [7:0] CH_CR = 8'h0D;
    localparam logic [7:0] CH_SP = 8'h20;
    localparam logic [7:0] CH_COLON = 8'h3A;
    localparam string VALUE_CHARS = "abcftx<>@;=:19 ";
    localparam int PHASE_BYTES = 165;
    localparam int PHASE_RESULTS = 16;
    localparam int HOLD_CYCLES = 300;

    typedef enum logic [3:0] {
        SC_MID = 4'd0, SC_BOL = 4'd1, SC_NAME = 4'd2, SC_VAL = 4'd3, SC_EOL = 4'd4,
        SC_F1 = 4'd5, SC_F2 = 4'd6, SC_F3 = 4'd7, SC_T1 = 4'd8, SC_C1 = 4'd9,
        SC_C2 = 4'd10, SC_C3 = 4'd11, SC_CSWS = 4'd12, SC_CSDIG = 4'd13
    } scan_t;

    typedef logic [7:0] byte_q_t[$];

    class span_scoreboard;
        scan_t       scan_q;
        int unsigned byte_off;
        int unsigned hdr_start;
        logic [2:0]  pend;
        logic [1:0]  cur_kind;
        bit          active;
        logic [2:0]  want_l;
        result_t     byte_spans[$];
        result_t     expected_spans[$];
        int unsigned errors;
        int unsigned predicted_count;

        function new();
            scan_q = SC_MID;
            byte_off = 0;
            hdr_start = 0;
            pend = 3'd0;
            cur_kind = KIND_FROM;
            active = 1'b0;
            want_l = 3'd0;
            errors = 0;
            predicted_count = 0;
        endfunction

        function void emit(logic [1:0] kind, int unsigned start, int unsigned len,
                           logic [1:0] stat);
            result_t r;
            r.kind = kind;
            r.start = start[FIELD_W-1:0];
            r.len = len[FIELD_W-1:0];
            r.status = stat;
            r.last = 1'b0;
            byte_spans.push_back(r);
        endfunction

        // Reports the current candidate; returns 1 once nothing is left to find.
        function bit close_header(int unsigned end_off);
            logic [2:0] hit;
            hit = 3'b001 << cur_kind;
            pend &= ~hit;
            emit(cur_kind, hdr_start, (end_off >= hdr_start) ? end_off - hdr_start : 0,
                 (pend != 3'd0) ? STAT_MORE : STAT_DONE);
            if (pend == 3'd0)
            begin
                active = 1'b0;
                return 1'b1;
            end
            return 1'b0;
        endfunction

        function bit is_space(logic [7:0] c);
            return c == CH_SP || (c >= CH_TAB && c <= CH_CR);
        endfunction

        function bit is_digit(logic [7:0] c);
            return c >= "0" && c <= "9";
        endfunction

        function void scan_basic(logic [7:0] c);
            scan_t s;
            logic [7:0] lc;
            s = (scan_q > SC_EOL) ? SC_MID : scan_q;
            lc = c | CASE_BIT;
            if (c == CH_LF || c == CH_CR)
            begin
                if (s == SC_NAME) s = SC_VAL;
                else if (s == SC_VAL || s == SC_EOL) s = SC_EOL;
                else s = SC_BOL;
                scan_q = s;
                return;
            end
            if (c == CH_SP || c == CH_TAB)
            begin
                if (s == SC_NAME || s == SC_EOL) s = SC_VAL;
                else if (s == SC_BOL) s = SC_MID;
                scan_q = s;
                return;
            end
            if (c == CH_COLON)
            begin
                if (s == SC_NAME || s == SC_VAL)
                    s = (cur_kind == KIND_CSEQ) ? SC_CSWS : SC_VAL;
                else if (s == SC_EOL)
                begin
                    if (close_header(byte_off)) return;
                    s = SC_MID;
                end
                else if (s == SC_BOL)
                    s = SC_MID;
                scan_q = s;
                return;
            end
            if (lc == "f" || lc == "t" || lc == "c")
            begin
                // Letters inside a value leave the state as it is.
                if (s == SC_VAL) return;
                if (s == SC_EOL)
                begin
                    if (close_header(byte_off)) return;
                    s = SC_BOL;
                end
                if (s != SC_BOL)
                begin
                    scan_q = SC_MID;
                    return;
                end
                scan_q = SC_BOL;
                if (lc == "f")
                begin
                    if (!want_l[0]) return;
                    cur_kind = KIND_FROM;
                    scan_q = SC_F1;
                end
                else if (lc == "t")
                begin
                    if (!want_l[1]) return;
                    cur_kind = KIND_TO;
                    scan_q = SC_T1;
                end
                else
                begin
                    if (!want_l[2]) return;
                    cur_kind = KIND_CSEQ;
                    scan_q = SC_C1;
                end
                hdr_start = byte_off;
                return;
            end
            if (s == SC_BOL || s == SC_NAME)
                s = SC_MID;
            else if (s == SC_EOL)
            begin
                if (close_header(byte_off)) return;
                s = SC_MID;
            end
            scan_q = s;
        endfunction

        // A partial name that breaks off falls back and looks at the byte again.
        function void rescan(scan_t back, logic [7:0] c);
            scan_q = back;
            scan_basic(c);
        endfunction

        function void scan_byte(logic [7:0] c);
            logic [7:0] lc;
            lc = c | CASE_BIT;
            case (scan_q)
                SC_F1: if (lc == "r") scan_q = SC_F2; else rescan(SC_NAME, c);
                SC_F2: if (lc == "o") scan_q = SC_F3; else rescan(SC_MID, c);
                SC_F3: if (lc == "m") scan_q = SC_NAME; else rescan(SC_MID, c);
                SC_T1: if (lc == "o") scan_q = SC_NAME; else rescan(SC_NAME, c);
                SC_C1: if (lc == "s") scan_q = SC_C2; else rescan(SC_BOL, c);
                SC_C2: if (lc == "e") scan_q = SC_C3; else rescan(SC_MID, c);
                SC_C3: if (lc == "q") scan_q = SC_NAME; else rescan(SC_MID, c);
                SC_CSWS, SC_CSDIG:
                begin
                    if (!(scan_q == SC_CSWS && is_space(c)))
                    begin
                        if (is_digit(c))
                            scan_q = SC_CSDIG;
                        else if (!close_header(byte_off))
                            scan_q = SC_MID;
                    end
                end
                default: scan_basic(c);
            endcase
        endfunction

        function void note_byte(logic [7:0] c, bit is_first, bit is_final,
                                logic [2:0] mask);
            byte_spans.delete();
            if (is_first)
            begin
                scan_q = SC_MID;
                byte_off = 0;
                hdr_start = 0;
                cur_kind = KIND_FROM;
                want_l = mask;
                pend = mask;
                active = 1'b1;
            end
            if (!active) return;
            scan_byte(c);
            if (is_final && active)
            begin
                // A CSeq number cut off by the buffer end runs through its last byte.
                if (scan_q == SC_CSWS || scan_q == SC_CSDIG)
                    void'(close_header((byte_off < OFF_MAX) ? byte_off + 1 : OFF_MAX));
                if (active)
                begin
                    emit(KIND_FROM, 0, 0, STAT_MISSING);
                    active = 1'b0;
                end
            end
            if (active && byte_off < OFF_MAX) byte_off++;
            if (byte_spans.size() > 0) byte_spans[byte_spans.size() - 1].last = 1'b1;
            foreach (byte_spans[i]) expected_spans.push_back(byte_spans[i]);
            predicted_count += byte_spans.size();
        endfunction

        function void check_field(string name, int unsigned exp_v, int unsigned act_v);
            if (exp_v != act_v)
            begin
                $error("%s: expected %0d, got %0d", name, exp_v, act_v);
                errors++;
            end
        endfunction

        function void check_result(result_t got);
            result_t exp_r;
            if (expected_spans.size() == 0)
            begin
                $error("unexpected result: kind %0d start %0d length %0d status %0d",
                       got.kind, got.start, got.len, got.status);
                errors++;
                return;
            end
            exp_r = expected_spans.pop_front();
            check_field("header_kind", exp_r.kind, got.kind);
            check_field("start_offset", exp_r.start, got.start);
            check_field("span_length", exp_r.len, got.len);
            check_field("status", exp_r.status, got.status);
            check_field("last_of_run", exp_r.last, got.last);
        endfunction

        function int outstanding();
            return expected_spans.size();
        endfunction

        function void flag_leftovers();
            foreach (expected_spans[i])
                $error("result never arrived: kind %0d start %0d length %0d status %0d",
                       expected_spans[i].kind, expected_spans[i].start,
                       expected_spans[i].len, expected_spans[i].status);
            errors += expected_spans.size();
        endfunction
    endclass

    logic               clk = 1'b0;
    logic               rst_n = 1'b0;
    logic               in_valid = 1'b0;
    logic               in_stall;
    logic [7:0]         data_byte = 8'd0;
    logic               first = 1'b0;
    logic               final_req = 1'b0;
    logic [2:0]         want_mask = 3'd0;
    logic               out_valid;
    logic               out_stall = 1'b0;
    logic [1:0]         header_kind;
    logic [FIELD_W-1:0] start_offset;
    logic [FIELD_W-1:0] span_length;
    logic [1:0]         status;
    logic               last_of_run;

    span_scoreboard sb = new();
    int snd_idle = 0;
    int rcv_idle = 0;
    bit long_hold = 1'b0;
    int bytes_sent = 0;

    sip_header_locator_core i_dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (in_valid),
        .in_stall     (in_stall),
        .data_byte    (data_byte),
        .first        (first),
        .final_req    (final_req),
        .want_mask    (want_mask),
        .out_valid    (out_valid),
        .out_stall    (out_stall),
        .header_kind  (header_kind),
        .start_offset (start_offset),
        .span_length  (span_length),
        .status       (status),
        .last_of_run  (last_of_run)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // Both channels are sampled before the edge's own updates take effect.
    always @(posedge clk)
    begin : monitor
        result_t got;
        if (rst_n)
        begin
            if (in_valid && !in_stall)
                sb.note_byte(data_byte, first, final_req, want_mask);
            if (out_valid && !out_stall)
            begin
                got.kind = header_kind;
                got.start = start_offset;
                got.len = span_length;
                got.status = status;
                got.last = last_of_run;
                sb.check_result(got);
            end
        end
    end

    initial
    begin : receiver
        forever
        begin
            @(posedge clk);
            if (long_hold)
            begin
                out_stall <= 1'b1;
                repeat (HOLD_CYCLES) @(posedge clk);
                long_hold = 1'b0;
            end
            else
                out_stall <= ($urandom_range(99) < rcv_idle);
        end
    end

    initial
    begin
        #6000000;
        $display("== FAIL ==");
        $finish;
    end

    // Called just after an edge; returns once the transfer has taken place.
    task automatic send_item(logic [7:0] b, bit f, bit l, logic [2:0] w);
        in_valid <= 1'b1;
        data_byte <= b;
        first <= f;
        final_req <= l;
        want_mask <= w;
        do @(posedge clk); while (in_stall);
        if ($urandom_range(99) < snd_idle)
        begin
            in_valid <= 1'b0;
            do @(posedge clk); while ($urandom_range(99) < snd_idle);
        end
    endtask

    task automatic send_buffer(byte_q_t q, logic [2:0] w, bit with_final);
        for (int i = 0; i < q.size(); i++)
        begin
            send_item(q[i], i == 0, with_final && i == q.size() - 1,
                      (i == 0) ? w : 3'($urandom_range(7)));
            bytes_sent++;
        end
    endtask

    // The count is read only after an edge, once the last transfer has been noted.
    task automatic drain();
        in_valid <= 1'b0;
        do @(posedge clk); while (sb.outstanding() != 0);
    endtask

    function automatic void push_text(ref byte_q_t q, input string s);
        for (int i = 0; i < s.len(); i++) q.push_back(s[i]);
    endfunction

    // Header names are matched without regard to case, so the case is mixed.
    function automatic void push_name(ref byte_q_t q, input string s);
        logic [7:0] c;
        for (int i = 0; i < s.len(); i++)
        begin
            c = s[i];
            if ((c | CASE_BIT) >= "a" && (c | CASE_BIT) <= "z" && $urandom_range(1))
                c ^= CASE_BIT;
            q.push_back(c);
        end
    endfunction

    function automatic void push_eol(ref byte_q_t q);
        case ($urandom_range(3))
            0, 1:
            begin
                q.push_back(CH_CR);
                q.push_back(CH_LF);
            end
            2: q.push_back(CH_LF);
            default: q.push_back(CH_CR);
        endcase
    endfunction

    function automatic void push_value(ref byte_q_t q);
        repeat ($urandom_range(0, 6))
        begin
            if ($urandom_range(7) == 0)
                q.push_back(8'($urandom_range(255)));
            else
                q.push_back(VALUE_CHARS[$urandom_range(VALUE_CHARS.len() - 1)]);
        end
    endfunction

    // Colon, value, an occasional folded continuation and the line end.
    function automatic void push_field_tail(ref byte_q_t q);
        if ($urandom_range(3) == 0) q.push_back(CH_SP);
        q.push_back(CH_COLON);
        push_value(q);
        if ($urandom_range(3) == 0)
        begin
            push_eol(q);
            q.push_back($urandom_range(1) ? CH_SP : CH_TAB);
            push_value(q);
        end
        push_eol(q);
    endfunction

    function automatic void push_header(ref byte_q_t q);
        case ($urandom_range(8))
            0, 1:
            begin
                if ($urandom_range(1)) push_name(q, "From");
                else push_name(q, "f");
                push_field_tail(q);
            end
            2, 3:
            begin
                if ($urandom_range(1)) push_name(q, "To");
                else push_name(q, "t");
                push_field_tail(q);
            end
            4, 5:
            begin
                push_name(q, "CSeq");
                if ($urandom_range(3) == 0) q.push_back(CH_SP);
                q.push_back(CH_COLON);
                repeat ($urandom_range(0, 2)) q.push_back($urandom_range(1) ? CH_SP : CH_TAB);
                repeat ($urandom_range(0, 4)) q.push_back(8'("0" + $urandom_range(9)));
                if ($urandom_range(1)) push_text(q, " REGISTER");
                push_eol(q);
            end
            6:
            begin
                // Names that share a prefix with a sought header.
                case ($urandom_range(8))
                    0: push_name(q, "Fro");
                    1: push_name(q, "Fr");
                    2: push_name(q, "Tx");
                    3: push_name(q, "Cs");
                    4: push_name(q, "Cse");
                    5: push_name(q, "CSex");
                    6: push_name(q, "Call-ID");
                    7: push_name(q, "Contact");
                    default: push_name(q, "Fromage");
                endcase
                push_field_tail(q);
            end
            7:
            begin
                push_value(q);
                push_eol(q);
            end
            default: push_eol(q);
        endcase
    endfunction

    function automatic void build_request(ref byte_q_t q);
        q.delete();
        case ($urandom_range(2))
            0: push_text(q, "INVITE s:b SIP/2.0");
            1: push_text(q, "BYE s");
            default: ;
        endcase
        push_eol(q);
        repeat ($urandom_range(1, 5)) push_header(q);
        if ($urandom_range(5) == 0)
        begin
            push_name(q, "CSeq");
            q.push_back(CH_COLON);
            repeat ($urandom_range(0, 3)) q.push_back(8'("0" + $urandom_range(9)));
        end
        else if ($urandom_range(1))
            push_text(q, "v=0");
    endfunction

    task automatic random_buffer();
        byte_q_t q;
        int pick;
        logic [2:0] w;
        bit with_final;
        pick = $urandom_range(9);
        w = ($urandom_range(7) == 0) ? 3'd0 : 3'($urandom_range(1, 7));
        with_final = 1'b1;
        if (pick < 8)
        begin
            build_request(q);
            if (pick == 7)
            begin
                // Broken request: cut short, with or without a last byte, or one byte spoilt.
                if ($urandom_range(1))
                begin
                    q = q[0:$urandom_range(q.size() - 1)];
                    with_final = 1'($urandom_range(1));
                end
                else
                    q[$urandom_range(q.size() - 1)] = 8'($urandom_range(255));
            end
        end
        else
        begin
            repeat ($urandom_range(1, 20)) q.push_back(8'($urandom_range(255)));
            with_final = ($urandom_range(3) != 0);
        end
        send_buffer(q, w, with_final);
        if ($urandom_range(3) == 0)
            repeat ($urandom_range(1, 3))
                send_item(8'($urandom_range(255)), 1'b0, 1'($urandom_range(1)),
                          3'($urandom_range(7)));
    endtask

    initial
    begin
        byte_q_t q;
        int bytes_mark;
        int res_mark;
        int waited;
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        for (int ph = 0; ph < 3; ph++)
        begin
            case (ph)
                0:
                begin
                    snd_idle = 25;
                    rcv_idle = 56;
                end
                1:
                begin
                    snd_idle = 56;
                    rcv_idle = 25;
                end
                default:
                begin
                    snd_idle = 0;
                    rcv_idle = 0;
                end
            endcase
            bytes_mark = bytes_sent;
            res_mark = sb.predicted_count;
            if (ph == 0)
            begin
                // A byte with no scan running, then an empty request.
                send_item(8'hFF, 1'b0, 1'b0, 3'd7);
                send_item(8'h00, 1'b1, 1'b1, 3'd0);
                q.delete();
                push_text(q, "\nTo:\nCSeq:9");
                send_buffer(q, 3'd7, 1'b1);
                q.delete();
                push_text(q, "\nf:\nF:\nx");
                send_buffer(q, 3'd3, 1'b1);
                drain();
                // The receiver holds off while one-byte requests keep coming.
                long_hold = 1'b1;
                repeat (24)
                    send_item(8'($urandom_range(255)), 1'b1, 1'b1, 3'($urandom_range(1, 7)));
            end
            while (bytes_sent - bytes_mark < PHASE_BYTES
                   || sb.predicted_count - res_mark < PHASE_RESULTS)
                random_buffer();
            drain();
        end
        waited = 0;
        while (sb.outstanding() != 0 && waited < 20000)
        begin
            @(posedge clk);
            waited++;
        end
        repeat (16) @(posedge clk);
        sb.flag_leftovers();
        if (sb.errors == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end

endmodule
